### hw/rtl/fsgs_pkg.sv
// Shared types and constants for the falling-sand grid step block.
package fsgs_pkg;

  localparam logic [1:0] CMD_PAINT  = 2'd0;
  localparam logic [1:0] CMD_STEP   = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] MAT_EMPTY = 2'd0;
  localparam logic [1:0] MAT_SAND  = 2'd1;
  localparam logic [1:0] MAT_WATER = 2'd2;
  localparam logic [1:0] MAT_WOOD  = 2'd3;

  typedef struct packed {
    logic       moved;
    logic [1:0] mat;
  } cell_t;

  // Datapath address selects.
  typedef enum logic [2:0] {
    TGT_SRC = 3'd0,
    TGT_D   = 3'd1,
    TGT_DR  = 3'd2,
    TGT_DL  = 3'd3,
    TGT_R   = 3'd4,
    TGT_L   = 3'd5,
    TGT_CMD = 3'd6
  } tgt_t;

  typedef struct packed {
    logic       clr_start;
    logic       clr_adv;
    logic       sw_start;
    logic       sw_adv;
    logic       rd_en;
    tgt_t       rd_tgt;
    logic       wr_en;
    tgt_t       wr_tgt;
    logic [2:0] wr_sel;   // 0 zero, 1 moved sand, 2 moved water, 3 read mat, 4 tgt mat, 5 paint
    logic       hold_src;
    logic       hold_tgt;
    logic       out_fire;
    logic       out_rd;
  } dp_cmd_t;

  localparam logic [2:0] WS_ZERO  = 3'd0;
  localparam logic [2:0] WS_SAND  = 3'd1;
  localparam logic [2:0] WS_WATER = 3'd2;
  localparam logic [2:0] WS_RDM   = 3'd3;
  localparam logic [2:0] WS_TGTM  = 3'd4;
  localparam logic [2:0] WS_PAINT = 3'd5;

  typedef struct packed {
    logic       clr_last;
    logic       sw_last;
    logic       in_grid;
    cell_t      src;
    cell_t      rdat;
    logic       has_below;
    logic       has_right;
    logic       has_left;
  } dp_stat_t;

endpackage

### hw/rtl/fsgs_ram.sv
// Generic single-port RAM with registered read.
module fsgs_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### hw/rtl/fsgs_datapath.sv
// Datapath: grid memory, sweep and clear counters, address and write data muxes.
module fsgs_datapath #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               start,
  input  logic               busy,
  input  logic [5:0]         cell_row,
  input  logic [5:0]         cell_col,
  input  logic [1:0]         paint_material,
  input  fsgs_pkg::dp_cmd_t  cmd,
  output fsgs_pkg::dp_stat_t stat,
  output logic               strobe,
  output logic [1:0]         cell_material,
  output logic               cell_moved
);
  import fsgs_pkg::*;

  localparam int RW    = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
  localparam int CW    = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
  localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [RW-1:0] RLAST = RW'(GRID_HEIGHT - 1);
  localparam logic [CW-1:0] CLAST = CW'(GRID_WIDTH - 1);

  logic [RW-1:0] r;
  logic [CW-1:0] c;
  logic [5:0]    q_row, q_col;
  logic [1:0]    q_mat;
  cell_t         src, tgt;
  logic          strobe_q;
  cell_t         out_q;
  cell_t         rdat, wdat;
  logic          we;
  logic [AW-1:0] addr;
  logic [RW-1:0] ar;
  logic [CW-1:0] ac;
  tgt_t          sel;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      q_row <= cell_row;
      q_col <= cell_col;
      q_mat <= paint_material;
    end
    if (cmd.clr_start || cmd.sw_start) begin
      r <= '0;
      c <= '0;
    end else if (cmd.clr_adv || cmd.sw_adv) begin
      if (c == CLAST) begin
        c <= '0;
        r <= r + RW'(1);
      end else begin
        c <= c + CW'(1);
      end
    end
    if (cmd.hold_src) src <= rdat;
    if (cmd.hold_tgt) tgt <= rdat;
    strobe_q <= cmd.out_fire;
    if (cmd.out_fire) out_q <= cmd.out_rd ? rdat : '0;
  end

  assign sel = cmd.wr_en ? cmd.wr_tgt : cmd.rd_tgt;

  always_comb begin
    ar = r;
    ac = c;
    unique case (sel)
      TGT_SRC: ;
      TGT_D:   ar = r + RW'(1);
      TGT_DR: begin
        ar = r + RW'(1);
        ac = c + CW'(1);
      end
      TGT_DL: begin
        ar = r + RW'(1);
        ac = c - CW'(1);
      end
      TGT_R:   ac = c + CW'(1);
      TGT_L:   ac = c - CW'(1);
      TGT_CMD: begin
        ar = RW'(q_row);
        ac = CW'(q_col);
      end
      default: ;
    endcase
  end

  assign addr = AW'(ar * GRID_WIDTH) + AW'(ac);

  always_comb begin
    case (cmd.wr_sel)
      WS_SAND:  wdat = '{moved: 1'b1, mat: MAT_SAND};
      WS_WATER: wdat = '{moved: 1'b1, mat: MAT_WATER};
      WS_RDM:   wdat = '{moved: 1'b0, mat: rdat.mat};
      WS_TGTM:  wdat = '{moved: 1'b0, mat: tgt.mat};
      WS_PAINT: wdat = '{moved: src.moved, mat: q_mat};
      default:  wdat = '0;
    endcase
  end

  assign we = cmd.wr_en;

  fsgs_ram #(.WIDTH(3), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .addr (addr),
    .wdata(wdat),
    .rdata(rdat)
  );

  assign stat.clr_last  = (r == RLAST) && (c == CLAST);
  assign stat.sw_last   = (r == RLAST) && (c == CLAST);
  assign stat.in_grid   = ({26'd0, q_row} < 32'(GRID_HEIGHT)) &&
                          ({26'd0, q_col} < 32'(GRID_WIDTH));
  assign stat.src       = src;
  assign stat.rdat      = rdat;
  assign stat.has_below = (r != RLAST);
  assign stat.has_right = (c != CLAST);
  assign stat.has_left  = (c != '0);

  assign strobe        = strobe_q;
  assign cell_material = out_q.mat;
  assign cell_moved    = out_q.moved;
endmodule

### hw/rtl/fsgs_ctrl.sv
// Controller state machine for commands, clearing pass and sweep.
module fsgs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         cmd_in,
  input  fsgs_pkg::dp_stat_t stat,
  output fsgs_pkg::dp_cmd_t  cmd,
  output logic               busy
);
  import fsgs_pkg::*;

  typedef enum logic [10:0] {
    S_CLR   = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_PRD   = 11'b00000000100,
    S_PWR   = 11'b00000001000,
    S_RRD   = 11'b00000010000,
    S_SRD   = 11'b00000100000,
    S_SEVAL = 11'b00001000000,
    S_TRD   = 11'b00010000000,
    S_TEVAL = 11'b00100000000,
    S_MOVE  = 11'b01000000000,
    S_NEXT  = 11'b10000000000
  } state_t;

  state_t state, state_next;
  tgt_t   t, t_next;
  logic [1:0] op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      t     <= TGT_D;
      op    <= CMD_PAINT;
    end else begin
      state <= state_next;
      t     <= t_next;
      if (start && !busy) op <= cmd_in;
    end
  end

  // Next target in try order; TGT_SRC means none left.
  function automatic tgt_t next_try(tgt_t cur, logic water, dp_stat_t s);
    tgt_t n;
    n = TGT_SRC;
    case (cur)
      TGT_D:  n = (s.has_below && s.has_right) ? TGT_DR
                : (s.has_below && s.has_left) ? TGT_DL
                : (water && s.has_right) ? TGT_R
                : (water && s.has_left) ? TGT_L : TGT_SRC;
      TGT_DR: n = (s.has_below && s.has_left) ? TGT_DL
                : (water && s.has_right) ? TGT_R
                : (water && s.has_left) ? TGT_L : TGT_SRC;
      TGT_DL: n = (water && s.has_right) ? TGT_R
                : (water && s.has_left) ? TGT_L : TGT_SRC;
      TGT_R:  n = s.has_left ? TGT_L : TGT_SRC;
      default: n = TGT_SRC;
    endcase
    return n;
  endfunction

  function automatic tgt_t first_try(logic water, dp_stat_t s);
    tgt_t n;
    if (s.has_below) n = TGT_D;
    else n = next_try(TGT_D, water, s);
    return n;
  endfunction

  logic water, ok;
  assign water = (stat.src.mat == MAT_WATER);
  assign ok = water ? (stat.rdat.mat == MAT_EMPTY)
                    : (stat.rdat.mat == MAT_EMPTY || stat.rdat.mat == MAT_WATER);

  always_comb begin
    state_next = state;
    t_next     = t;
    cmd        = '0;
    cmd.rd_tgt = TGT_SRC;
    cmd.wr_tgt = TGT_SRC;
    busy       = 1'b1;
    unique case (state)
      S_CLR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WS_ZERO;
        cmd.clr_adv = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (cmd_in)
            CMD_PAINT: state_next = S_PRD;
            CMD_READ:  state_next = S_RRD;
            CMD_STEP: begin
              cmd.sw_start = 1'b1;
              state_next   = S_SRD;
            end
            default: begin
              cmd.out_fire = 1'b1;
            end
          endcase
        end
      end
      S_PRD: begin
        cmd.rd_tgt = TGT_CMD;
        state_next = S_PWR;
      end
      S_PWR: begin
        cmd.hold_src = 1'b1;
        state_next   = S_NEXT;
      end
      S_RRD: begin
        cmd.rd_tgt = TGT_CMD;
        state_next = S_NEXT;
      end
      S_SRD: begin
        cmd.rd_tgt = TGT_SRC;
        state_next = S_SEVAL;
      end
      S_SEVAL: begin
        cmd.hold_src = 1'b1;
        if (stat.rdat.moved) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_tgt = TGT_SRC;
          cmd.wr_sel = WS_RDM;
          state_next = S_NEXT;
        end else if (stat.rdat.mat == MAT_SAND && stat.has_below) begin
          t_next     = TGT_D;
          state_next = S_TRD;
        end else if (stat.rdat.mat == MAT_WATER &&
                     first_try(1'b1, stat) != TGT_SRC) begin
          t_next     = first_try(1'b1, stat);
          state_next = S_TRD;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_TRD: begin
        cmd.rd_tgt = t;
        state_next = S_TEVAL;
      end
      S_TEVAL: begin
        cmd.hold_tgt = 1'b1;
        if (ok) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_tgt = t;
          cmd.wr_sel = water ? WS_WATER : WS_SAND;
          state_next = S_MOVE;
        end else if (next_try(t, water, stat) != TGT_SRC) begin
          t_next     = next_try(t, water, stat);
          state_next = S_TRD;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_MOVE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_tgt = TGT_SRC;
        cmd.wr_sel = water ? WS_ZERO : WS_TGTM;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        if (op == CMD_STEP) begin
          if (stat.sw_last) begin
            cmd.out_fire = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.sw_adv = 1'b1;
            state_next = S_SRD;
          end
        end else if (op == CMD_PAINT) begin
          if (stat.in_grid) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_tgt = TGT_CMD;
            cmd.wr_sel = WS_PAINT;
          end
          cmd.out_fire = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.out_fire = 1'b1;
          cmd.out_rd   = stat.in_grid;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (rst) begin
      cmd           = '0;
      cmd.rd_tgt    = TGT_SRC;
      cmd.wr_tgt    = TGT_SRC;
      cmd.clr_start = 1'b1;
      busy          = 1'b1;
    end
  end
endmodule

### hw/rtl/falling_sand_grid_step.sv
// Top level of the falling-sand grid step block.
//  channel | signals                                          | handshake
//  command | start, cmd, cell_row, cell_col, paint_material   | start && !busy
//  result  | strobe, cell_material, cell_moved                | strobe, one cycle
// Paint runs S_PRD, S_PWR and S_NEXT, read runs S_RRD and S_NEXT, from acceptance to the registered strobe.
// Step sweeps every cell of the grid in turn on the single RAM port.
// After reset a clearing pass writes every cell, busy high.
// The receiver cannot stall; each result is marked by strobe for one cycle.
module falling_sand_grid_step #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd,
  input  logic [5:0] cell_row,
  input  logic [5:0] cell_col,
  input  logic [1:0] paint_material,
  output logic       strobe,
  output logic [1:0] cell_material,
  output logic       cell_moved
);
  import fsgs_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t stat;

  fsgs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd_in(cmd),
    .stat  (stat),
    .cmd   (dcmd),
    .busy  (busy)
  );

  fsgs_datapath #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_dp (
    .clk           (clk),
    .start         (start),
    .busy          (busy),
    .cell_row      (cell_row),
    .cell_col      (cell_col),
    .paint_material(paint_material),
    .cmd           (dcmd),
    .stat          (stat),
    .strobe        (strobe),
    .cell_material (cell_material),
    .cell_moved    (cell_moved)
  );
endmodule

### dv/falling_sand_grid_step_checker.sv
// Checker for falling_sand_grid_step: models the grid, predicts and compares each result.
module falling_sand_grid_step_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] cmd,
  input  logic [5:0] cell_row,
  input  logic [5:0] cell_col,
  input  logic [1:0] paint_material,
  input  logic       strobe,
  input  logic [1:0] cell_material,
  input  logic       cell_moved,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fsgs_pkg::*;

  localparam int ROWS = 64;
  localparam int COLS = 64;

  cell_t grid_model [ROWS*COLS];
  cell_t expected_cells [$];

  function automatic logic [1:0] mat_at(int r, int c);
    return grid_model[r*COLS+c].mat;
  endfunction

  function automatic bit sand_falls(int r, int c, int tr, int tc);
    logic [1:0] t;
    t = mat_at(tr, tc);
    if (t != MAT_EMPTY && t != MAT_WATER) return 0;
    grid_model[tr*COLS+tc] = '{moved: 1'b1, mat: MAT_SAND};
    grid_model[r*COLS+c] = '{moved: 1'b0, mat: t};
    return 1;
  endfunction

  function automatic bit water_flows(int r, int c, int tr, int tc);
    if (mat_at(tr, tc) != MAT_EMPTY) return 0;
    grid_model[tr*COLS+tc] = '{moved: 1'b1, mat: MAT_WATER};
    grid_model[r*COLS+c] = '{moved: 1'b0, mat: MAT_EMPTY};
    return 1;
  endfunction

  function automatic void sweep_grid();
    cell_t v;
    bit dn, rt, lf;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        v = grid_model[r*COLS+c];
        dn = r + 1 < ROWS;
        rt = c + 1 < COLS;
        lf = c > 0;
        if (v.moved) begin
          grid_model[r*COLS+c].moved = 1'b0;
        end else if (v.mat == MAT_SAND && dn) begin
          if (!sand_falls(r, c, r+1, c))
            if (!(rt && sand_falls(r, c, r+1, c+1)))
              if (lf) void'(sand_falls(r, c, r+1, c-1));
        end else if (v.mat == MAT_WATER) begin
          if (!(dn && water_flows(r, c, r+1, c)))
            if (!(dn && rt && water_flows(r, c, r+1, c+1)))
              if (!(dn && lf && water_flows(r, c, r+1, c-1)))
                if (!(rt && water_flows(r, c, r, c+1)))
                  if (lf) void'(water_flows(r, c, r, c-1));
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    cell_t exp_cell;
    if (rst) begin
      foreach (grid_model[i]) grid_model[i] = '0;
      expected_cells.delete();
      fail_count <= 0;
    end else begin
      if (strobe) begin
        if (expected_cells.size() == 0) begin
          if (fail_count < 10)
            $display("mismatch: result with no transaction pending, mat=%0d moved=%0d",
                     cell_material, cell_moved);
          fail_count <= fail_count + 1;
        end else begin
          exp_cell = expected_cells.pop_front();
          if (exp_cell.mat !== cell_material || exp_cell.moved !== cell_moved) begin
            if (fail_count < 10)
              $display("mismatch: expected mat=%0d moved=%0d, got mat=%0d moved=%0d",
                       exp_cell.mat, exp_cell.moved, cell_material, cell_moved);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        exp_cell = '0;
        case (cmd)
          CMD_PAINT: grid_model[cell_row*COLS+cell_col].mat = paint_material;
          CMD_STEP:  sweep_grid();
          CMD_READ:  exp_cell = grid_model[cell_row*COLS+cell_col];
          default: ;
        endcase
        expected_cells = {expected_cells, exp_cell};
      end
    end
    pending = expected_cells.size();
  end
endmodule

### dv/testbench.sv
// Testbench top for falling_sand_grid_step: drives commands and reports the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fsgs_pkg::*;

  localparam longint CYCLE_LIMIT = 20000000;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] cmd;
  logic [5:0] cell_row;
  logic [5:0] cell_col;
  logic [1:0] paint_material;
  logic       strobe;
  logic [1:0] cell_material;
  logic       cell_moved;
  int         fail_count;
  int         pending;
  logic       taken;
  longint     cycle_count;
  int         idle_pct;

  falling_sand_grid_step u_dut (
    .clk, .rst, .start, .busy, .cmd, .cell_row, .cell_col, .paint_material,
    .strobe, .cell_material, .cell_moved
  );

  falling_sand_grid_step_checker u_checker (
    .clk, .rst, .start, .busy, .cmd, .cell_row, .cell_col, .paint_material,
    .strobe, .cell_material, .cell_moved, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    taken <= start && !busy;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL falling_sand_grid_step");
      $finish;
    end
  end

  task automatic issue(logic [1:0] c, logic [5:0] r, logic [5:0] col, logic [1:0] m);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    cmd = c;
    cell_row = r;
    cell_col = col;
    paint_material = m;
    do @(negedge clk); while (!taken);
    start = 1'b0;
  endtask

  task automatic random_transaction();
    int sel;
    logic [5:0] r, c;
    sel = $urandom_range(99);
    if ($urandom_range(3) == 0) begin
      r = 6'($urandom);
      c = 6'($urandom);
    end else begin
      r = 6'($urandom_range(63, 56));
      c = $urandom_range(1) ? 6'($urandom_range(7)) : 6'($urandom_range(63, 56));
    end
    if (sel < 10)      issue(CMD_STEP, 6'($urandom), 6'($urandom), 2'($urandom));
    else if (sel < 13) issue(CMD_UNUSED, r, c, 2'($urandom));
    else if (sel < 60) issue(CMD_PAINT, r, c, 2'($urandom));
    else               issue(CMD_READ, r, c, 2'($urandom));
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_PAINT;
    cell_row = '0;
    cell_col = '0;
    paint_material = MAT_EMPTY;
    cycle_count = 0;
    idle_pct = 0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    issue(CMD_READ, 6'd0, 6'd0, MAT_EMPTY);
    issue(CMD_PAINT, 6'd0, 6'd0, MAT_SAND);
    issue(CMD_PAINT, 6'd0, 6'd63, MAT_WATER);
    issue(CMD_PAINT, 6'd63, 6'd63, MAT_WOOD);
    issue(CMD_PAINT, 6'd63, 6'd0, MAT_WATER);
    issue(CMD_PAINT, 6'd62, 6'd0, MAT_SAND);
    issue(CMD_PAINT, 6'd62, 6'd63, MAT_WATER);
    issue(CMD_PAINT, 6'd63, 6'd62, MAT_SAND);
    issue(CMD_UNUSED, 6'd63, 6'd63, MAT_EMPTY);
    issue(CMD_STEP, 6'd0, 6'd0, MAT_EMPTY);
    issue(CMD_READ, 6'd1, 6'd0, MAT_EMPTY);
    issue(CMD_READ, 6'd63, 6'd0, MAT_EMPTY);
    issue(CMD_READ, 6'd62, 6'd0, MAT_EMPTY);
    issue(CMD_PAINT, 6'd1, 6'd0, MAT_WOOD);
    issue(CMD_READ, 6'd1, 6'd0, MAT_EMPTY);
    issue(CMD_STEP, 6'd0, 6'd0, MAT_EMPTY);
    issue(CMD_READ, 6'd1, 6'd0, MAT_EMPTY);
    issue(CMD_READ, 6'd62, 6'd63, MAT_EMPTY);
    issue(CMD_PAINT, 6'd63, 6'd63, MAT_EMPTY);
    issue(CMD_STEP, 6'd0, 6'd0, MAT_EMPTY);
    issue(CMD_READ, 6'd63, 6'd63, MAT_EMPTY);

    idle_pct = 16;
    repeat (27) random_transaction();
    idle_pct = 73;
    repeat (26) random_transaction();
    idle_pct = 0;
    repeat (26) random_transaction();

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS falling_sand_grid_step");
    end else begin
      $display("FAIL falling_sand_grid_step");
    end
    $finish;
  end
endmodule

### files.f
hw/rtl/fsgs_pkg.sv
hw/rtl/fsgs_ram.sv
hw/rtl/fsgs_datapath.sv
hw/rtl/fsgs_ctrl.sv
hw/rtl/falling_sand_grid_step.sv
dv/falling_sand_grid_step_checker.sv
dv/testbench.sv
